// ===== sv/obt_pkg.sv =====
// ----------------------------------------------------------------------------
// obt_pkg: shared types and constants for the oldest-first buffer table
// Holds field widths, the command code and the control state encoding.
// ----------------------------------------------------------------------------
package obt_pkg;

  localparam int unsigned NumW = 30;
  localparam int unsigned OccW = 4;

  typedef logic [NumW-1:0] num_t;
  typedef logic [OccW-1:0] occ_t;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StShift,
    StDone
  } state_e;

endpackage

// ===== sv/obt_if.sv =====
// ----------------------------------------------------------------------------
// obt_if: stream interfaces of the oldest-first buffer table
// Command beats enter on obt_in_if, one result beat leaves on obt_out_if.
// ----------------------------------------------------------------------------
interface obt_in_if;
  logic          valid;
  logic          ready;
  logic          command;
  obt_pkg::num_t buffer_number;

  modport source (output valid, output command, output buffer_number, input ready);
  modport sink   (input valid, input command, input buffer_number, output ready);
endinterface

interface obt_out_if;
  logic          valid;
  logic          ready;
  logic          value_valid;
  obt_pkg::num_t popped_number;
  logic          dropped;
  obt_pkg::occ_t occupancy;

  modport source (output valid, output value_valid, output popped_number, output dropped,
                  output occupancy, input ready);
  modport sink   (input valid, input value_valid, input popped_number, input dropped,
                  input occupancy, output ready);
endinterface

// ===== sv/oldest_first_buffer_table.sv =====
// Sequence: a push into a table with room writes the entry, then reports;
//   a push into a full table first scans every entry for the minimum; a pop scans
//   likewise and, unless it removes the top entry, shifts each entry above it down.
// Throughput: one beat at a time, set by the single read port of the entry memory
//   that is scanned for the minimum and then walked to close the gap.
// Reset: the entry count clears at once; the entry memory is left unwritten.
// ----------------------------------------------------------------------------
// oldest_first_buffer_table: bounded table that pops its smallest number
// Push appends or overwrites the smallest entry when full; pop removes the
// smallest entry (lowest slot on ties) and shifts later entries down.
// ----------------------------------------------------------------------------
module oldest_first_buffer_table #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  obt_in_if.sink    in_i,
  obt_out_if.source out_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  obt_pkg::state_e state_q, state_d;
  obt_pkg::cmd_e   cmd_q;
  obt_pkg::num_t   num_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   rd_idx_q;
  logic            rd_vld_q;
  logic [AW-1:0]   rd_tag_q;
  obt_pkg::num_t   rd_data_q;
  obt_pkg::num_t   min_q;
  logic [AW-1:0]   slot_q;

  obt_pkg::num_t   mem_q [TABLE_DEPTH];

  logic            in_acc;
  logic            out_free;
  logic            last_tag;
  logic            issue;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  obt_pkg::num_t   mem_wd;
  obt_pkg::cmd_e   in_cmd;

  obt_pkg::num_t   res_popped;
  logic            res_vvalid;
  logic            res_dropped;

  assign in_cmd   = obt_pkg::cmd_e'(in_i.command);
  assign in_i.ready = (state_q == obt_pkg::StIdle);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_o.valid || out_o.ready;
  assign last_tag = (CW'(rd_tag_q) == count_q - CW'(1));
  assign issue    = ((state_q == obt_pkg::StScan) || (state_q == obt_pkg::StShift)) &&
                    (rd_idx_q < count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      obt_pkg::StIdle: begin
        if (in_acc) begin
          if (in_cmd == obt_pkg::CmdPush) begin
            state_d = (count_q < Depth) ? obt_pkg::StDone : obt_pkg::StScan;
          end else begin
            state_d = (count_q == '0) ? obt_pkg::StDone : obt_pkg::StScan;
          end
        end
      end
      obt_pkg::StScan: begin
        if (rd_vld_q && last_tag) state_d = obt_pkg::StDecide;
      end
      obt_pkg::StDecide: begin
        if (cmd_q == obt_pkg::CmdPush || CW'(slot_q) == count_q - CW'(1)) begin
          state_d = obt_pkg::StDone;
        end else begin
          state_d = obt_pkg::StShift;
        end
      end
      obt_pkg::StShift: begin
        if (rd_vld_q && last_tag) state_d = obt_pkg::StDone;
      end
      obt_pkg::StDone: begin
        if (out_free) state_d = obt_pkg::StIdle;
      end
      default: state_d = obt_pkg::StIdle;
    endcase
  end

  // memory write and result control
  always_comb begin
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = num_q;
    count_d     = count_q;
    res_vvalid  = 1'b0;
    res_popped  = '0;
    res_dropped = 1'b0;
    unique case (state_q)
      obt_pkg::StIdle: begin
        if (in_acc && in_cmd == obt_pkg::CmdPush && count_q < Depth) begin
          mem_we = 1'b1;
          mem_wa = count_q[AW-1:0];
          mem_wd = in_i.buffer_number;
        end
      end
      obt_pkg::StDecide: begin
        if (cmd_q == obt_pkg::CmdPush) begin
          mem_we = 1'b1;
          mem_wa = slot_q;
          mem_wd = num_q;
        end
      end
      obt_pkg::StShift: begin
        if (rd_vld_q) begin
          mem_we = 1'b1;
          mem_wa = rd_tag_q - AW'(1);
          mem_wd = rd_data_q;
        end
      end
      obt_pkg::StDone: begin
        if (cmd_q == obt_pkg::CmdPush) begin
          if (count_q >= Depth) begin
            res_dropped = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
          end
        end else if (count_q != '0) begin
          res_vvalid = 1'b1;
          res_popped = min_q;
          count_d    = count_q - CW'(1);
        end
        if (!out_free) count_d = count_q;
      end
      obt_pkg::StScan: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (issue) rd_data_q <= mem_q[rd_idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= obt_pkg::StIdle;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      out_o.valid <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= issue;
      if (in_acc) begin
        rd_idx_q <= '0;
      end else if (state_q == obt_pkg::StDecide) begin
        rd_idx_q <= CW'(slot_q) + CW'(1);
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + CW'(1);
      end
      if (state_q == obt_pkg::StDone && out_free) begin
        out_o.valid <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_cmd;
      num_q <= in_i.buffer_number;
    end
    if (issue) rd_tag_q <= rd_idx_q[AW-1:0];
    if (state_q == obt_pkg::StScan && rd_vld_q) begin
      if (rd_tag_q == '0 || rd_data_q < min_q) begin
        min_q  <= rd_data_q;
        slot_q <= rd_tag_q;
      end
    end
    if (state_q == obt_pkg::StDone && out_free) begin
      out_o.value_valid   <= res_vvalid;
      out_o.popped_number <= res_popped;
      out_o.dropped       <= res_dropped;
      out_o.occupancy     <= obt_pkg::OccW'(count_d);
    end
  end

endmodule
